/* design/i2c_master_byte_sequencer_defines.svh */
// assertion macros for the i2c master byte sequencer checker
// no dependencies; included by the checker file
`ifndef I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define I2CMBS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define I2CMBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/i2cmbs_pkg.sv */
// shared types and constants of the i2c master byte sequencer
// no dependencies; imported by every module of the block
package i2cmbs_pkg;

   // command codes on the request channel
   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   // register indexes of the csr port
   localparam logic [1:0] CSR_LONG_WAIT  = 2'd0;
   localparam logic [1:0] CSR_HALF_BIT   = 2'd1;
   localparam logic [1:0] CSR_SHORT_WAIT = 2'd2;

   // register reset values
   localparam logic [15:0] LONG_WAIT_RESET  = 16'd20;
   localparam logic [15:0] HALF_BIT_RESET   = 16'd10;
   localparam logic [15:0] SHORT_WAIT_RESET = 16'd1;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // running command
   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   // request item
   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data_byte;
      logic       ack_to_send;
      logic       sda_in;
   } req_type;

   // response item
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_received;
      logic       rejected;
   } rsp_type;

   // phase timing registers
   typedef struct packed {
      logic [15:0] long_wait;
      logic [15:0] half_bit;
      logic [15:0] short_wait;
   } wait_cfg_type;

   // sequencer state apart from the wait counter; levels[1] scl, levels[0] sda
   typedef struct packed {
      op_type     op;
      logic [3:0] phase;
      logic [3:0] bit_cnt;
      logic [7:0] shift;
      logic [1:0] levels;
      logic       sampled_ack;
      logic [7:0] rx_hold;
      logic       ack_hold;
   } seq_state_type;

endpackage

/* design/i2cmbs_step.sv */
// next-state logic of the i2c pin sequencer for one tick item
// depends on i2cmbs_pkg
module i2cmbs_step #(
   parameter int WAIT_WIDTH = 16
) (
   input  i2cmbs_pkg::seq_state_type cur_state,
   input  logic [WAIT_WIDTH-1:0]     cur_wait,
   input  i2cmbs_pkg::req_type       req,
   input  i2cmbs_pkg::wait_cfg_type  cfg,
   output i2cmbs_pkg::seq_state_type nxt_state,
   output logic [WAIT_WIDTH-1:0]     nxt_wait,
   output logic                      done,
   output logic                      rejected
);
   import i2cmbs_pkg::*;

   localparam int CW = (WAIT_WIDTH > 16) ? WAIT_WIDTH : 16;

   // start and stop phases
   localparam logic [3:0] C_FIRST  = 4'd0;
   localparam logic [3:0] C_SECOND = 4'd1;
   localparam logic [3:0] C_LAST   = 4'd2;
   // write phases
   localparam logic [3:0] W_SETUP    = 4'd0;
   localparam logic [3:0] W_CLK_HIGH = 4'd1;
   localparam logic [3:0] W_HOLD     = 4'd2;
   localparam logic [3:0] W_ACK_REL  = 4'd3;
   localparam logic [3:0] W_ACK_HIGH = 4'd4;
   localparam logic [3:0] W_ACK_HOLD = 4'd5;
   localparam logic [3:0] W_END      = 4'd6;
   // read phases
   localparam logic [3:0] R_CLK_HIGH  = 4'd0;
   localparam logic [3:0] R_CLK_HOLD  = 4'd1;
   localparam logic [3:0] R_CLK_LOW   = 4'd2;
   localparam logic [3:0] R_ACK_SETUP = 4'd3;
   localparam logic [3:0] R_ACK_HIGH  = 4'd4;
   localparam logic [3:0] R_ACK_HOLD  = 4'd5;

   // zero counts as one tick, values above the counter range saturate
   function automatic logic [WAIT_WIDTH-1:0] clamp_wait(input logic [15:0] w);
      logic [15:0]   v;
      logic [CW-1:0] wide;
      logic [CW-1:0] lim;
      v    = (w == 16'd0) ? 16'd1 : w;
      wide = CW'(v);
      lim  = CW'({WAIT_WIDTH{1'b1}});
      return (wide > lim) ? lim[WAIT_WIDTH-1:0] : wide[WAIT_WIDTH-1:0];
   endfunction

   seq_state_type         mid;
   logic [WAIT_WIDTH-1:0] mid_wait;
   logic                  enter;
   logic                  cmd_valid;
   logic [3:0]            bit_inc;
   logic [1:0]            lvl;
   logic [15:0]           wait_sel;

   assign cmd_valid = req.cmd inside {CMD_START, CMD_STOP, CMD_WRITE, CMD_READ};
   assign bit_inc   = 4'(cur_state.bit_cnt + 4'd1);

   // command launch, wait countdown and phase expiry
   always_comb begin
      mid      = cur_state;
      mid_wait = cur_wait;
      enter    = 1'b0;
      done     = 1'b0;
      rejected = 1'b0;
      if (cur_state.op == OP_IDLE) begin
         if (cmd_valid) begin
            mid.op      = op_type'(req.cmd);
            mid.phase   = 4'd0;
            mid.bit_cnt = 4'd0;
            if (req.cmd == CMD_WRITE) begin
               mid.shift = req.data_byte;
            end
            if (req.cmd == CMD_READ) begin
               mid.shift    = 8'd0;
               mid.ack_hold = req.ack_to_send;
            end
            enter = 1'b1;
         end
      end else begin
         rejected = cmd_valid;
         if (cur_wait <= WAIT_WIDTH'(1)) begin
            mid_wait = '0;
            enter    = 1'b1;
            case (cur_state.op)
               OP_START, OP_STOP: begin
                  if (cur_state.phase >= C_LAST) begin
                     done  = 1'b1;
                     enter = 1'b0;
                  end else begin
                     mid.phase = 4'(cur_state.phase + 4'd1);
                  end
               end
               OP_WRITE: begin
                  if (cur_state.phase == W_HOLD) begin
                     mid.shift   = {cur_state.shift[6:0], 1'b0};
                     mid.bit_cnt = bit_inc;
                     mid.phase   = (bit_inc >= BITS_PER_BYTE) ? W_ACK_REL : W_SETUP;
                  end else begin
                     if (cur_state.phase == W_ACK_HIGH) begin
                        mid.sampled_ack = req.sda_in;
                     end
                     if (cur_state.phase >= W_END) begin
                        done  = 1'b1;
                        enter = 1'b0;
                     end else begin
                        mid.phase = 4'(cur_state.phase + 4'd1);
                     end
                  end
               end
               default: begin
                  // read
                  if (cur_state.phase == R_CLK_HIGH) begin
                     mid.shift = {cur_state.shift[6:0], req.sda_in};
                  end
                  if (cur_state.phase == R_CLK_LOW) begin
                     mid.bit_cnt = bit_inc;
                     mid.phase   = (bit_inc >= BITS_PER_BYTE) ? R_ACK_SETUP : R_CLK_HIGH;
                  end else if (cur_state.phase >= R_ACK_HOLD) begin
                     mid.rx_hold = mid.shift;
                     mid.levels  = 2'b01;
                     done        = 1'b1;
                     enter       = 1'b0;
                  end else begin
                     mid.phase = 4'(cur_state.phase + 4'd1);
                  end
               end
            endcase
            if (done) begin
               mid.op      = OP_IDLE;
               mid.phase   = 4'd0;
               mid.bit_cnt = 4'd0;
            end
         end else begin
            mid_wait = cur_wait - WAIT_WIDTH'(1);
         end
      end
   end

   // pin levels and hold time of the phase being entered
   always_comb begin
      lvl      = mid.levels;
      wait_sel = cfg.short_wait;
      case (mid.op)
         OP_START: begin
            wait_sel = cfg.long_wait;
            case (mid.phase)
               C_FIRST:  lvl = 2'b11;
               C_SECOND: lvl = 2'b10;
               default:  lvl = 2'b00;
            endcase
         end
         OP_STOP: begin
            wait_sel = cfg.long_wait;
            case (mid.phase)
               C_FIRST:  lvl = 2'b00;
               C_SECOND: lvl = 2'b10;
               default:  lvl = 2'b11;
            endcase
         end
         OP_WRITE: begin
            if (mid.phase == W_SETUP || mid.phase == W_HOLD) begin
               wait_sel = cfg.half_bit;
            end
            case (mid.phase)
               W_SETUP:                lvl = {1'b0, mid.shift[7]};
               W_CLK_HIGH:             lvl = {1'b1, mid.shift[7]};
               W_HOLD:                 lvl = {1'b0, mid.shift[7]};
               W_ACK_REL:              lvl = 2'b01;
               W_ACK_HIGH, W_ACK_HOLD: lvl = 2'b11;
               default:                lvl = 2'b01;
            endcase
         end
         OP_READ: begin
            case (mid.phase)
               R_CLK_HIGH, R_CLK_HOLD: lvl = 2'b11;
               R_CLK_LOW:              lvl = 2'b01;
               R_ACK_SETUP:            lvl = {1'b0, mid.ack_hold};
               R_ACK_HIGH:             lvl = {1'b1, mid.ack_hold};
               default:                lvl = {1'b0, mid.ack_hold};
            endcase
         end
         default: begin
            lvl = mid.levels;
         end
      endcase
   end

   // apply the new phase only when one is entered
   always_comb begin
      nxt_state = mid;
      nxt_wait  = mid_wait;
      if (enter) begin
         nxt_state.levels = lvl;
         nxt_wait         = clamp_wait(wait_sel);
      end
   end

endmodule

/* design/i2c_master_byte_sequencer.sv */
// i2c master pin sequencer, top level; depends on i2cmbs_pkg and i2cmbs_step
// the result of an item is registered and shown in the cycle after it is accepted
// throughput: one item per cycle; req_ready drops only while a result waits
//   in the output register and rsp_ready is low
// reset (synchronous): idle, both lines released, wait registers 20/10/1
module i2c_master_byte_sequencer #(
   parameter int WAIT_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  i2cmbs_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output i2cmbs_pkg::rsp_type  rsp_data,
   input  logic                 csr_write_en,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata
);
   import i2cmbs_pkg::*;

   wait_cfg_type          cfg_ff;
   seq_state_type         state_ff;
   logic [WAIT_WIDTH-1:0] wait_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   seq_state_type         state_in;
   logic [WAIT_WIDTH-1:0] wait_in;
   rsp_type               rsp_in;
   logic                  step_done;
   logic                  step_rejected;
   logic                  accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_wait  <= LONG_WAIT_RESET;
         cfg_ff.half_bit   <= HALF_BIT_RESET;
         cfg_ff.short_wait <= SHORT_WAIT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_LONG_WAIT:  cfg_ff.long_wait  <= csr_wdata;
            CSR_HALF_BIT:   cfg_ff.half_bit   <= csr_wdata;
            CSR_SHORT_WAIT: cfg_ff.short_wait <= csr_wdata;
            default: ;
         endcase
      end
   end

   i2cmbs_step #(
      .WAIT_WIDTH (WAIT_WIDTH)
   ) u_step (
      .cur_state (state_ff),
      .cur_wait  (wait_ff),
      .req       (req_data),
      .cfg       (cfg_ff),
      .nxt_state (state_in),
      .nxt_wait  (wait_in),
      .done      (step_done),
      .rejected  (step_rejected)
   );

   // result fields from the updated state
   always_comb begin
      rsp_in.scl_out      = state_in.levels[1];
      rsp_in.sda_out      = state_in.levels[0];
      rsp_in.busy_res     = (state_in.op != OP_IDLE);
      rsp_in.done_res     = step_done;
      rsp_in.rx_byte      = state_in.rx_hold;
      rsp_in.ack_received = state_in.sampled_ack;
      rsp_in.rejected     = step_rejected;
   end

   // sequencer state advances once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.op          <= OP_IDLE;
         state_ff.phase       <= 4'd0;
         state_ff.bit_cnt     <= 4'd0;
         state_ff.shift       <= 8'd0;
         state_ff.levels      <= 2'b11;
         state_ff.sampled_ack <= 1'b1;
         state_ff.rx_hold     <= 8'd0;
         state_ff.ack_hold    <= 1'b0;
         wait_ff              <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* design/i2cmbs_checker.sv */
// port-level assertions of the i2c master byte sequencer, bound to the top level
// depends on i2cmbs_pkg and i2c_master_byte_sequencer_defines.svh
`include "i2c_master_byte_sequencer_defines.svh"

module i2cmbs_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input i2cmbs_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input i2cmbs_pkg::rsp_type rsp_data
);
   import i2cmbs_pkg::*;

   // a stalled result holds
   `I2CMBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // input side never stalls while the output register is empty
   `I2CMBS_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready, "input stalled with empty output")

   // every accepted item gives a result in the next cycle
   `I2CMBS_ASSERT_NEXT(a_one_result, req_valid && req_ready, rsp_valid, "accepted item gave no result")

   // a finishing command leaves the sequencer idle
   `I2CMBS_ASSERT_NOW(a_done_idle, rsp_valid && rsp_data.done_res, !rsp_data.busy_res, "done while still busy")

   // a plain tick is never flagged as rejected
   `I2CMBS_ASSERT_NEXT(a_tick_not_rejected, req_valid && req_ready && req_data.cmd == CMD_TICK, !rsp_data.rejected, "tick flagged as rejected")

endmodule

bind i2c_master_byte_sequencer i2cmbs_checker u_i2cmbs_checker (.*);
